FILE: src/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define SPTC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define SPTC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: src/sptc_pkg.sv
package sptc_pkg;

   // register indexes of the csr port
   localparam logic [1:0] REG_INDEX_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_SLOPE_TANGENT   = 2'd1;
   localparam logic [1:0] REG_JET_MODE        = 2'd2;

   // reset values
   localparam logic [15:0] THRESHOLD_RESET = 16'd52429;
   localparam logic [15:0] TANGENT_RESET   = 16'd256;

   // fixed colors
   localparam logic [23:0] COLOR_RED   = 24'hFF0000;
   localparam logic [23:0] COLOR_BLACK = 24'h000000;

   // point class codes
   localparam logic [1:0] CLS_FAIL  = 2'd0;
   localparam logic [1:0] CLS_BLACK = 2'd1;
   localparam logic [1:0] CLS_COLOR = 2'd2;

   // per-item flags carried through the divider
   typedef struct packed {
      logic fail;
      logic above;
   } ctl_type;

endpackage

FILE: src/sptc_div_step.sv
module sptc_div_step #(
   parameter int QW = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              v_in,
   input  sptc_pkg::ctl_type ctl_in,
   input  logic [16:0]       rem_in,
   input  logic [16:0]       den_in,
   input  logic [QW-1:0]     q_in,
   output logic              v_out,
   output sptc_pkg::ctl_type ctl_out,
   output logic [16:0]       rem_out,
   output logic [16:0]       den_out,
   output logic [QW-1:0]     q_out
);
   import sptc_pkg::*;

   logic          v_ff;
   ctl_type       ctl_ff;
   logic [16:0]   rem_ff, rem_in_nx;
   logic [16:0]   den_ff;
   logic [QW-1:0] q_ff, q_in_nx;
   logic [17:0]   shifted;
   logic [17:0]   trial;

   // one restoring step: shift, try subtract, keep on success
   always_comb begin
      shifted = {rem_in, 1'b0};
      trial   = shifted - {1'b0, den_in};
      if (shifted >= {1'b0, den_in}) begin
         rem_in_nx = trial[16:0];
         q_in_nx   = {q_in[QW-2:0], 1'b1};
      end else begin
         rem_in_nx = shifted[16:0];
         q_in_nx   = {q_in[QW-2:0], 1'b0};
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff <= ctl_in;
         rem_ff <= rem_in_nx;
         den_ff <= den_in;
         q_ff   <= q_in_nx;
      end
   end

   assign v_out   = v_ff;
   assign ctl_out = ctl_ff;
   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign q_out   = q_ff;

endmodule

FILE: src/surface_point_traversability_colorizer.sv
// channel   dir  handshake               payload
// req_      in   req_tvalid/req_tready   tdata: nx, ny, nz, unevenness_index
// rsp_      out  rsp_tvalid/rsp_tready   tdata: color_rgb; tuser: point_class
// csr_      in   csr_we                  csr_addr index, csr_wdata value
//
// one word accepted per cycle while req_tready is high; a result word passes through
// stages a, b and c, then the restoring divider that spends one stage per quotient
// bit, then stages e and o
// synchronous active-high reset empties all stages and restores the registers
// each stage moves when the one after it is empty or moving, so bubbles close
// up and a stalled output holds its word while earlier stages keep filling
module surface_point_traversability_colorizer #(
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // nx, ny, nz, unevenness_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // color_rgb
   output logic [1:0]  rsp_tuser,  // point_class
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import sptc_pkg::*;

   localparam int F = FRACTION_BITS;

   // configuration registers
   logic [15:0] thr_ff, tan_ff;
   logic        jet_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
         tan_ff <= TANGENT_RESET;
         jet_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_INDEX_THRESHOLD: thr_ff <= csr_wdata;
            REG_SLOPE_TANGENT:   tan_ff <= csr_wdata;
            REG_JET_MODE:        jet_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage enables, back to front
   logic         en_a, en_b, en_c, en_e, en_o;
   logic [F-1:0] en_d;
   logic         a_v_ff, b_v_ff, c_v_ff, e_v_ff, o_v_ff;
   logic [F-1:0] dv;

   assign en_o = !o_v_ff || rsp_tready;
   assign en_e = !e_v_ff || en_o;
   assign en_c = !c_v_ff || en_d[0];
   assign en_b = !b_v_ff || en_c;
   assign en_a = !a_v_ff || en_b;
   assign req_tready = en_a;

   // stage a: input word
   logic signed [15:0] a_nx_ff, a_ny_ff, a_nz_ff;
   logic [15:0]        a_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en_a) begin
         a_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_nx_ff  <= req_tdata[15:0];
         a_ny_ff  <= req_tdata[31:16];
         a_nz_ff  <= req_tdata[47:32];
         a_idx_ff <= req_tdata[63:48];
      end
   end

   // stage b: tangent times ny, index offset and divisor
   logic signed [32:0] b_prod_in, b_prod_ff;
   logic signed [15:0] b_nx_ff, b_nz_ff;
   logic               b_ny_pos_ff, b_ny_neg_ff, b_above_ff;
   logic [15:0]        b_diff_ff;
   logic [16:0]        b_den_ff;

   assign b_prod_in = $signed({1'b0, tan_ff}) * a_ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en_b) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         b_prod_ff   <= b_prod_in;
         b_nx_ff     <= a_nx_ff;
         b_nz_ff     <= a_nz_ff;
         b_ny_pos_ff <= !a_ny_ff[15] && (a_ny_ff != 16'sd0);
         b_ny_neg_ff <= a_ny_ff[15];
         b_above_ff  <= a_idx_ff > thr_ff;
         b_diff_ff   <= a_idx_ff - thr_ff;
         b_den_ff    <= 17'h10000 - {1'b0, thr_ff};
      end
   end

   // stage c: slope test
   logic signed [32:0] lhs_x, lhs_z;
   logic               fail_x, fail_z;
   ctl_type            c_ctl_ff;
   logic [16:0]        c_rem_ff, c_den_ff;

   always_comb begin
      lhs_x  = {{9{b_nx_ff[15]}}, b_nx_ff, 8'h00};
      lhs_z  = {{9{b_nz_ff[15]}}, b_nz_ff, 8'h00};
      fail_x = (b_ny_pos_ff && (lhs_x > b_prod_ff)) || (b_ny_neg_ff && (lhs_x < b_prod_ff));
      fail_z = (b_ny_pos_ff && (lhs_z > b_prod_ff)) || (b_ny_neg_ff && (lhs_z < b_prod_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en_c) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_ctl_ff.fail  <= fail_x || fail_z;
         c_ctl_ff.above <= b_above_ff;
         c_rem_ff       <= {1'b0, b_diff_ff};
         c_den_ff       <= b_den_ff;
      end
   end

   // divider: one quotient bit per stage
   ctl_type      dctl [F];
   logic [16:0]  drem [F];
   logic [16:0]  dden [F];
   logic [F-1:0] dq   [F];

   for (genvar k = 0; k < F; k++) begin : g_div
      if (k == F - 1) begin : g_last
         assign en_d[k] = !dv[k] || en_e;
      end else begin : g_mid
         assign en_d[k] = !dv[k] || en_d[k+1];
      end
      if (k == 0) begin : g_first
         sptc_div_step #(.QW(F)) u_step (
            .clock(clock), .reset(reset), .en(en_d[k]),
            .v_in(c_v_ff), .ctl_in(c_ctl_ff), .rem_in(c_rem_ff),
            .den_in(c_den_ff), .q_in('0),
            .v_out(dv[k]), .ctl_out(dctl[k]), .rem_out(drem[k]),
            .den_out(dden[k]), .q_out(dq[k])
         );
      end else begin : g_next
         sptc_div_step #(.QW(F)) u_step (
            .clock(clock), .reset(reset), .en(en_d[k]),
            .v_in(dv[k-1]), .ctl_in(dctl[k-1]), .rem_in(drem[k-1]),
            .den_in(dden[k-1]), .q_in(dq[k-1]),
            .v_out(dv[k]), .ctl_out(dctl[k]), .rem_out(drem[k]),
            .den_out(dden[k]), .q_out(dq[k])
         );
      end
   end

   // stage e: rainbow segment and ramp, jet terms
   logic [F-1:0]  vq;
   logic [F+2:0]  p6;
   logic [F+7:0]  ramp;
   logic [F:0]    w;
   logic [F+10:0] jprod, jprod_up;
   logic [1:0]    e_cls_ff, e_jseg_ff;
   logic          e_jet_ff;
   logic [2:0]    e_n_ff;
   logic [7:0]    e_t_ff;
   logic [10:0]   e_fl_ff, e_ce_ff;

   always_comb begin
      vq       = dq[F-1];
      p6       = {3'b000, vq} * (F+3)'(6);
      ramp     = ({8'h00, p6[F-1:0]} << 8) - {8'h00, p6[F-1:0]};
      w        = {1'b1, {F{1'b0}}} - {1'b0, vq};
      jprod    = {10'd0, w} * (F+11)'(1020);
      jprod_up = jprod + (F+11)'((1 << F) - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (en_e) begin
         e_v_ff <= dv[F-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         if (dctl[F-1].fail) begin
            e_cls_ff <= CLS_FAIL;
         end else if (dctl[F-1].above) begin
            e_cls_ff <= CLS_COLOR;
         end else begin
            e_cls_ff <= CLS_BLACK;
         end
         e_jet_ff  <= jet_ff;
         e_n_ff    <= p6[F+2:F];
         e_t_ff    <= ramp[F+7:F];
         e_fl_ff   <= jprod[F+10:F];
         e_ce_ff   <= jprod_up[F+10:F];
         e_jseg_ff <= w[F] ? 2'd3 : w[F-1:F-2];
      end
   end

   // stage o: color select and output register
   logic [23:0] rainbow_rgb, jet_rgb, color_in;
   logic [23:0] o_rgb_ff;
   logic [1:0]  o_cls_ff;

   always_comb begin
      case (e_n_ff)
         3'd0:    rainbow_rgb = {8'h00, 8'hFF, e_t_ff};
         3'd1:    rainbow_rgb = {8'h00, 8'hFF - e_t_ff, 8'hFF};
         3'd2:    rainbow_rgb = {e_t_ff, 8'h00, 8'hFF};
         3'd3:    rainbow_rgb = {8'hFF, 8'h00, 8'hFF - e_t_ff};
         3'd4:    rainbow_rgb = {8'hFF, e_t_ff, 8'h00};
         3'd5:    rainbow_rgb = {8'hFF - e_t_ff, 8'hFF, 8'h00};
         default: rainbow_rgb = {8'h00, 8'hFF, 8'h00};
      endcase
      case (e_jseg_ff)
         2'd0:    jet_rgb = {8'h00, e_ce_ff[7:0], 8'hFF};
         2'd1:    jet_rgb = {8'h00, 8'hFF, 8'(11'd510 - e_fl_ff)};
         2'd2:    jet_rgb = {8'(e_ce_ff - 11'd510), 8'hFF, 8'h00};
         default: jet_rgb = {8'hFF, 8'(11'd1020 - e_fl_ff), 8'h00};
      endcase
      case (e_cls_ff)
         CLS_FAIL:  color_in = COLOR_RED;
         CLS_COLOR: color_in = e_jet_ff ? jet_rgb : rainbow_rgb;
         default:   color_in = COLOR_BLACK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (en_o) begin
         o_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_o) begin
         o_rgb_ff <= color_in;
         o_cls_ff <= e_cls_ff;
      end
   end

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = o_rgb_ff;
   assign rsp_tuser  = o_cls_ff;

   // checks
   `include "assert_macros.svh"

   `SPTC_ASSERT(a_fail_red, rsp_tvalid && (rsp_tuser == CLS_FAIL) |-> rsp_tdata == COLOR_RED, "failed point not red")
   `SPTC_ASSERT(a_black, rsp_tvalid && (rsp_tuser == CLS_BLACK) |-> rsp_tdata == COLOR_BLACK, "low point not black")
   `SPTC_ASSERT(a_cls_code, rsp_tvalid |-> rsp_tuser != 2'd3, "undefined point class")
   `SPTC_ASSERT(a_rem_bound, dv[F-1] && dctl[F-1].above |-> drem[F-1] < dden[F-1], "divider remainder out of range")
   `SPTC_ASSERT_ALWAYS(a_ready_after_reset, reset |=> req_tready, "not ready after reset")

endmodule

FILE: verif/tb.sv
module tb;
   import sptc_pkg::*;

   localparam int FB = 16;
   localparam int LATENCY = FB + 5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;  // nx, ny, nz, unevenness_index
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // color_rgb
   logic [1:0]  rsp_tuser;       // point_class
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   typedef struct packed {
      logic [23:0] rgb;
      logic [1:0]  cls;
   } color_word_type;

   color_word_type expected_colors[$];
   logic [15:0] cur_threshold;
   logic [15:0] cur_tangent;
   logic        cur_jet;
   int          mismatch_count = 0;

   surface_point_traversability_colorizer #(.FRACTION_BITS(FB)) u_dut (.*);

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   initial begin
      #20000000;
      $display("tb: FAIL");
      $finish;
   end

   task automatic report(input string what);
      mismatch_count++;
      $display("tb: mismatch %s", what);
   endtask

   // exact test of n/d > tan with tan in q8.8
   function automatic bit slope_too_steep(logic signed [15:0] n, logic signed [15:0] d,
                                          logic [15:0] tan);
      longint lhs, rhs;
      lhs = longint'(n) * 256;
      rhs = longint'(tan) * longint'(d);
      if (d > 0) return lhs > rhs;
      if (d < 0) return lhs < rhs;
      return 1'b0;
   endfunction

   function automatic logic [23:0] rgb(longint r, longint g, longint b);
      return {r[7:0], g[7:0], b[7:0]};
   endfunction

   function automatic color_word_type colorize_point(logic [63:0] d);
      longint one, num, den, vq, p, n, t, wq, prod, fl, ce;
      logic [15:0] idx;
      color_word_type c;
      one = longint'(1) << FB;
      idx = d[63:48];
      if (slope_too_steep(d[15:0], d[31:16], cur_tangent) ||
          slope_too_steep(d[47:32], d[31:16], cur_tangent)) begin
         c.rgb = COLOR_RED;
         c.cls = CLS_FAIL;
      end else if (idx > cur_threshold) begin
         num = longint'(idx - cur_threshold) << FB;
         den = 65536 - longint'(cur_threshold);
         vq = num / den;
         if (vq > one) vq = one;
         c.cls = CLS_COLOR;
         if (!cur_jet) begin
            p = vq * 6;
            n = p >> FB;
            t = ((p & (one - 1)) * 255) >> FB;
            case (n)
               0: c.rgb = rgb(0, 255, t);
               1: c.rgb = rgb(0, 255 - t, 255);
               2: c.rgb = rgb(t, 0, 255);
               3: c.rgb = rgb(255, 0, 255 - t);
               4: c.rgb = rgb(255, t, 0);
               5: c.rgb = rgb(255 - t, 255, 0);
               default: c.rgb = rgb(0, 255, 0);
            endcase
         end else begin
            wq = one - vq;
            prod = wq * 1020;
            fl = prod >> FB;
            ce = (prod + one - 1) >> FB;
            if (wq * 4 < one) c.rgb = rgb(0, ce, 255);
            else if (wq * 4 < one * 2) c.rgb = rgb(0, 255, 510 - fl);
            else if (wq * 4 < one * 3) c.rgb = rgb(ce - 510, 255, 0);
            else c.rgb = rgb(255, 1020 - fl, 0);
         end
      end else begin
         c.rgb = COLOR_BLACK;
         c.cls = CLS_BLACK;
      end
      return c;
   endfunction

   // result checker with random stalls
   initial begin
      int stall;
      color_word_type want;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (expected_colors.size() == 0) begin
            report($sformatf("unexpected word rgb=%h cls=%0d", rsp_tdata, rsp_tuser));
         end else begin
            want = expected_colors.pop_front();
            if (rsp_tdata !== want.rgb)
               report($sformatf("color_rgb got %h want %h", rsp_tdata, want.rgb));
            if (rsp_tuser !== want.cls)
               report($sformatf("point_class got %0d want %0d", rsp_tuser, want.cls));
         end
      end
   end

   bit burst_mode = 1'b0;

   task automatic send_point(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                             logic [15:0] idx);
      int gap;
      logic [63:0] d;
      d = {idx, nz, ny, nx};
      gap = burst_mode ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      expected_colors.insert(expected_colors.size(), colorize_point(d));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] addr, logic [15:0] val);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (addr)
         REG_INDEX_THRESHOLD: cur_threshold = val;
         REG_SLOPE_TANGENT:   cur_tangent = val;
         REG_JET_MODE:        cur_jet = val[0];
         default: ;
      endcase
   endtask

   // extremes, zero and negative ny, ties, threshold boundary
   task automatic test_directed();
      send_point(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      send_point(16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF);
      send_point(16'h4000, 16'h4000, 16'h4000, 16'hFFFF);  // ratio equal to tangent
      send_point(16'h4001, 16'h4000, 16'h0000, 16'hFFFF);
      send_point(16'h0000, 16'h4000, 16'h4001, 16'hFFFF);
      send_point(16'hC000, 16'hC000, 16'h0000, 16'hFFFF);  // negative ny tie
      send_point(16'hBFFF, 16'hC000, 16'h0000, 16'hFFFF);
      send_point(16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
      send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
      send_point(16'h0000, 16'h1000, 16'h0000, cur_threshold);
      send_point(16'h0000, 16'h1000, 16'h0000, cur_threshold + 16'd1);
      send_point(16'h0000, 16'h1000, 16'h0000, 16'h0000);
      send_point(16'h0000, 16'h1000, 16'h0000, 16'hF000);
   endtask

   task automatic test_sweep(int count);
      int i;
      logic [15:0] nx, ny, nz, idx;
      for (i = 0; i < count; i++) begin
         burst_mode = ($urandom_range(0, 7) == 0);
         ny = $urandom;
         nx = $urandom;
         nz = $urandom;
         if ($urandom_range(0, 2) != 0) begin
            // mostly passing orientation so colors are exercised
            ny = $urandom_range(16'h2000, 16'h7FFF);
            nx = $signed(16'($urandom_range(0, 32767))) >>> $urandom_range(1, 8);
            nz = $signed(16'($urandom)) >>> $urandom_range(2, 8);
            if ($urandom_range(0, 1)) nx = -nx;
         end
         if ($urandom_range(0, 15) == 0) ny = 16'h0000;
         idx = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                           : 16'($urandom_range(cur_threshold, 16'hFFFF));
         send_point(nx, ny, nz, idx);
      end
      burst_mode = 1'b0;
   endtask

   task automatic test_settings();
      logic [15:0] thr [6] = '{16'd0, 16'hFFFF, 16'hFFFE, 16'h8000, 16'd100, 16'hC000};
      logic [15:0] tan [6] = '{16'd0, 16'hFFFF, 16'd256, 16'd64, 16'd1024, 16'h8000};
      int k;
      for (k = 0; k < 6; k++) begin
         drain();
         write_reg(REG_INDEX_THRESHOLD, thr[k]);
         write_reg(REG_SLOPE_TANGENT, tan[k]);
         write_reg(REG_JET_MODE, 16'(k % 2));
         if (k == 2) test_directed();
         test_sweep(130);
      end
   endtask

   initial begin
      cur_threshold = THRESHOLD_RESET;
      cur_tangent = TANGENT_RESET;
      cur_jet = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_sweep(40);
      test_settings();
      drain();
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
